// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a at a clock edge implies b at the same edge
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a at a clock edge implies b at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- design/sirl_pkg.sv -----
// Soft interrupt rate limiter: operation codes, status codes and field widths.
// No dependencies.
package sirl_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_RAISE    = 3'd1,
    OP_TICK     = 3'd2,
    OP_ACK      = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXISTS  = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_UNREG   = 3'd4;

  localparam logic [1:0] ACK_BUSY = 2'd2;
  localparam logic [1:0] ACK_DONE = 2'd3;

  localparam logic [1:0] CFG_TICK_DIVIDER = 2'd0;
  localparam logic [1:0] CFG_LIMIT        = 2'd1;
  localparam logic [1:0] CFG_EXEMPT_TYPE  = 2'd2;
  localparam logic [1:0] CFG_EXEMPT_ID    = 2'd3;

  localparam logic [7:0] SAT_MAX = 8'hFF;

  // packed from the top bit down: status ends up in the lowest bits
  typedef struct packed {
    logic       period_start;
    logic [7:0] free_credit;
    logic [2:0] slot_index;
    logic       deliver;
    logic [2:0] status;
  } result_t;

endpackage

// ----- design/soft_interrupt_rate_limiter_top.sv -----
// Soft interrupt rate limiter top level: source table memory, scan sequencer
// and result register. Depends on sirl_pkg and assert_macros.svh.
//
// Usage:
//   Items enter on s_tvalid/s_tready; s_tuser carries the op code and s_tdata
//   the source type, source id and ack code. Each item yields exactly one
//   result beat on m_tvalid/m_tready (status, deliver, slot, credit, period
//   start). Configuration registers are written through cfg_we/cfg_index/
//   cfg_data while the block is idle.
//   Register and raise scan the source table memory one entry per cycle over
//   its single read port, then move to the result state. Tick, ack, clear and
//   unused codes go straight from accept to the result state.
//   One item is in flight at a time; s_tready is high only when idle, so a new
//   item is accepted only after the last result has been loaded.
//   Reset clears the entry valid bits, the counter valid bits, the credit
//   (to one), the tick count and the configuration registers to defaults.
//   A stalled receiver holds the result register; the finished item waits in
//   its final state, and no table update takes place until the beat is free
//   to load, so state and results stay in step.
`include "assert_macros.svh"

module soft_interrupt_rate_limiter_top #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] source_type, [15:8] source_id, [17:16] ack_code
  input  logic [2:0]  s_tuser,   // [2:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] status, [3] deliver, [6:4] slot_index,
                                 // [14:7] free_credit, [15] period_start
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t state;

  logic [7:0] tick_divider, per_period_limit, exempt_type, exempt_id;
  logic [7:0] credit, tick_count;

  logic [2:0] item_op;
  logic [7:0] item_type, item_id;
  logic [1:0] item_ack;

  logic [TABLE_DEPTH-1:0] valid, cvalid;

  logic [23:0] mem [TABLE_DEPTH];
  logic [23:0] mem_rd;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0] mem_wd;

  logic [CW-1:0] cnt;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  logic          found;
  logic [AW-1:0] hit_idx;
  logic [7:0]    hit_count;

  logic          free_ok;
  logic [AW-1:0] free_idx;
  logic          issue;
  logic          fire;
  logic          exempt;
  logic [8:0]    tick_inc;
  logic          period;

  sirl_pkg::result_t res;
  logic [7:0]    credit_next, tick_count_next;
  logic [TABLE_DEPTH-1:0] valid_next, cvalid_next;
  logic [AW+2:0] slot_wide;
  logic [AW-1:0] slot_sel;

  assign s_tready = (state == IDLE);
  assign issue    = (state == SCAN) && (cnt < CW'(TABLE_DEPTH));
  assign fire     = (state == FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider     <= 8'd10;
      per_period_limit <= 8'd3;
      exempt_type      <= 8'd0;
      exempt_id        <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sirl_pkg::CFG_TICK_DIVIDER: tick_divider     <= cfg_data;
        sirl_pkg::CFG_LIMIT:        per_period_limit <= cfg_data;
        sirl_pkg::CFG_EXEMPT_TYPE:  exempt_type      <= cfg_data;
        sirl_pkg::CFG_EXEMPT_ID:    exempt_id        <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      mem_rd <= mem[cnt[AW-1:0]];
    end
  end

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_ok  = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign exempt   = (exempt_type != 8'd0) && (item_type == exempt_type) &&
                    (item_id == exempt_id);
  assign tick_inc = {1'b0, tick_count} + 9'd1;
  assign period   = tick_inc >= {1'b0, tick_divider};

  always_comb begin
    res             = '0;
    slot_sel        = '0;
    credit_next     = credit;
    tick_count_next = tick_count;
    valid_next      = valid;
    cvalid_next     = cvalid;
    mem_we          = 1'b0;
    mem_wa          = hit_idx;
    mem_wd          = {hit_count, item_id, item_type};
    res.status      = sirl_pkg::ST_OK;
    case (item_op)
      sirl_pkg::OP_REGISTER: begin
        priority if (item_type == 8'd0) begin
          res.status = sirl_pkg::ST_REFUSED;
        end else if (found) begin
          res.status = sirl_pkg::ST_EXISTS;
          slot_sel   = hit_idx;
        end else if (free_ok) begin
          slot_sel              = free_idx;
          mem_we                = fire;
          mem_wa                = free_idx;
          mem_wd                = {8'd0, item_id, item_type};
          valid_next[free_idx]  = 1'b1;
          cvalid_next[free_idx] = 1'b0;
        end else begin
          res.status = sirl_pkg::ST_NOSPACE;
        end
      end
      sirl_pkg::OP_RAISE: begin
        priority if (credit == 8'd0) begin
          res.status = sirl_pkg::ST_REFUSED;
        end else if (!found) begin
          res.status = sirl_pkg::ST_UNREG;
        end else if (!exempt && (hit_count >= per_period_limit)) begin
          res.status = sirl_pkg::ST_REFUSED;
          slot_sel   = hit_idx;
        end else begin
          slot_sel             = hit_idx;
          res.deliver          = 1'b1;
          mem_we               = fire;
          mem_wd               = {(hit_count == sirl_pkg::SAT_MAX) ? hit_count
                                  : hit_count + 8'd1, item_id, item_type};
          cvalid_next[hit_idx] = 1'b1;
        end
      end
      sirl_pkg::OP_TICK: begin
        if (period) begin
          tick_count_next  = 8'd0;
          cvalid_next      = '0;
          res.period_start = 1'b1;
        end else begin
          tick_count_next = tick_inc[7:0];
        end
      end
      sirl_pkg::OP_ACK: begin
        if (item_ack == sirl_pkg::ACK_BUSY) begin
          credit_next = 8'd0;
        end else if (item_ack == sirl_pkg::ACK_DONE && credit != sirl_pkg::SAT_MAX) begin
          credit_next = credit + 8'd1;
        end
      end
      sirl_pkg::OP_CLEAR: begin
        valid_next  = '0;
        cvalid_next = '0;
        credit_next = 8'd1;
      end
      default: ;
    endcase
    slot_wide       = {3'b000, slot_sel};
    res.slot_index  = slot_wide[2:0];
    res.free_credit = credit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      m_tvalid   <= 1'b0;
      valid      <= '0;
      cvalid     <= '0;
      credit     <= 8'd1;
      tick_count <= 8'd0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
    end else begin
      if (m_tvalid && m_tready && !fire) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            item_op   <= s_tuser;
            item_type <= s_tdata[7:0];
            item_id   <= s_tdata[15:8];
            item_ack  <= s_tdata[17:16];
            found     <= 1'b0;
            rd_valid  <= 1'b0;
            cnt       <= '0;
            hit_idx   <= '0;
            hit_count <= '0;
            if (s_tuser == sirl_pkg::OP_REGISTER || s_tuser == sirl_pkg::OP_RAISE) begin
              state <= SCAN;
            end else begin
              state <= FINISH;
            end
          end
        end
        SCAN: begin
          rd_valid <= issue;
          if (issue) begin
            rd_idx <= cnt[AW-1:0];
            cnt    <= cnt + CW'(1);
          end
          if (rd_valid && !found && valid[rd_idx] &&
              mem_rd[7:0] == item_type && mem_rd[15:8] == item_id) begin
            found     <= 1'b1;
            hit_idx   <= rd_idx;
            hit_count <= cvalid[rd_idx] ? mem_rd[23:16] : 8'd0;
          end
          if (!issue && rd_valid) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (fire) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= res;
            credit     <= credit_next;
            tick_count <= tick_count_next;
            valid      <= valid_next;
            cvalid     <= cvalid_next;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_deliver_ok, clk, rst, m_tvalid && m_tdata[3], m_tdata[2:0] == sirl_pkg::ST_OK)
  `ASSERT_IMPLY(a_deliver_credit, clk, rst, m_tvalid && m_tdata[3], m_tdata[14:7] != 8'd0)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for soft_interrupt_rate_limiter_top: directed and random
// register/raise/tick/ack/clear beats checked against an in-bench predictor.
// Depends on sirl_pkg and the design files only.
`timescale 1ns / 100ps

module tb;

  localparam int TBL_DEPTH = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_GAP = 6;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] ACK_NONE = 2'd0;
  localparam logic [1:0] ACK_PROGRESS = 2'd1;

  typedef struct {
    logic [2:0] op;
    logic [7:0] stype;
    logic [7:0] sid;
    logic [1:0] ack;
  } cmd_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] source_type, [15:8] source_id, [17:16] ack_code
  logic [2:0]  s_tuser = '0;   // [2:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [2:0] status, [3] deliver, [6:4] slot_index,
                               // [14:7] free_credit, [15] period_start
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  soft_interrupt_rate_limiter_top #(.TABLE_DEPTH(TBL_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // limiter state as the bench sees it
  logic [7:0] src_type [TBL_DEPTH];
  logic [7:0] src_id [TBL_DEPTH];
  logic [7:0] src_hits [TBL_DEPTH];
  logic [7:0] credit_left = 8'd1;
  logic [7:0] tick_phase = 8'd0;
  logic [7:0] div_cfg = 8'd10;
  logic [7:0] limit_cfg = 8'd3;
  logic [7:0] exempt_type_cfg = 8'd0;
  logic [7:0] exempt_id_cfg = 8'd0;

  cmd_t              pending_cmds[$];
  sirl_pkg::result_t predicted_results[$];
  int      fail_count = 0;
  int      sender_idle = 0;
  int      recv_stall = 0;
  int      hold_left = 0;
  int      cycle_count = 0;

  initial begin
    for (int k = 0; k < TBL_DEPTH; k++) begin
      src_type[k] = '0;
      src_id[k] = '0;
      src_hits[k] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sirl_pkg::result_t predict_outcome(input cmd_t c);
    sirl_pkg::result_t r;
    int hit;
    logic [8:0] nxt;
    r = '0;
    hit = -1;
    if (c.stype != 8'd0) begin
      for (int k = 0; k < TBL_DEPTH; k++)
        if (hit < 0 && src_type[k] == c.stype && src_id[k] == c.sid) hit = k;
    end
    case (c.op)
      sirl_pkg::OP_REGISTER: begin
        if (c.stype == 8'd0) begin
          r.status = sirl_pkg::ST_REFUSED;
        end else if (hit >= 0) begin
          r.status = sirl_pkg::ST_EXISTS;
          r.slot_index = hit[2:0];
        end else begin
          r.status = sirl_pkg::ST_NOSPACE;
          for (int k = 0; k < TBL_DEPTH; k++) begin
            if (r.status == sirl_pkg::ST_NOSPACE && src_type[k] == 8'd0) begin
              src_type[k] = c.stype;
              src_id[k] = c.sid;
              src_hits[k] = 8'd0;
              r.status = sirl_pkg::ST_OK;
              r.slot_index = k[2:0];
            end
          end
        end
      end
      sirl_pkg::OP_RAISE: begin
        if (credit_left == 8'd0) begin
          r.status = sirl_pkg::ST_REFUSED;
        end else if (hit < 0) begin
          r.status = sirl_pkg::ST_UNREG;
        end else begin
          r.slot_index = hit[2:0];
          if (!(exempt_type_cfg != 8'd0 && c.stype == exempt_type_cfg &&
                c.sid == exempt_id_cfg) && src_hits[hit] >= limit_cfg) begin
            r.status = sirl_pkg::ST_REFUSED;
          end else begin
            if (src_hits[hit] != sirl_pkg::SAT_MAX) src_hits[hit] = src_hits[hit] + 8'd1;
            r.deliver = 1'b1;
          end
        end
      end
      sirl_pkg::OP_TICK: begin
        nxt = {1'b0, tick_phase} + 9'd1;
        if (nxt >= {1'b0, div_cfg}) begin
          tick_phase = 8'd0;
          for (int k = 0; k < TBL_DEPTH; k++) src_hits[k] = 8'd0;
          r.period_start = 1'b1;
        end else begin
          tick_phase = nxt[7:0];
        end
      end
      sirl_pkg::OP_ACK: begin
        if (c.ack == sirl_pkg::ACK_BUSY) credit_left = 8'd0;
        else if (c.ack == sirl_pkg::ACK_DONE && credit_left != sirl_pkg::SAT_MAX)
          credit_left = credit_left + 8'd1;
      end
      sirl_pkg::OP_CLEAR: begin
        for (int k = 0; k < TBL_DEPTH; k++) begin
          src_type[k] = 8'd0;
          src_id[k] = 8'd0;
          src_hits[k] = 8'd0;
        end
        credit_left = 8'd1;
      end
      default: ;
    endcase
    r.free_credit = credit_left;
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // source driver
  always @(posedge clk) begin : drive_proc
    cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        c = pending_cmds.pop_front();
        predicted_results.push_back(predict_outcome(c));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle) begin
          c = pending_cmds[0];
          s_tvalid <= 1'b1;
          s_tuser <= c.op;
          s_tdata <= {6'd0, c.ack, c.sid, c.stype};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin : check_proc
    sirl_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_results.size() == 0) begin
        note_failure($sformatf("result beat %h with nothing outstanding", m_tdata));
      end else begin
        want = predicted_results.pop_front();
        if (m_tdata[2:0] !== want.status || m_tdata[3] !== want.deliver ||
            m_tdata[6:4] !== want.slot_index || m_tdata[14:7] !== want.free_credit ||
            m_tdata[15] !== want.period_start)
          note_failure($sformatf(
            "exp status %0d deliver %0d slot %0d credit %0d pstart %0d, got %0d %0d %0d %0d %0d",
            want.status, want.deliver, want.slot_index, want.free_credit, want.period_start,
            m_tdata[2:0], m_tdata[3], m_tdata[6:4], m_tdata[14:7], m_tdata[15]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: run did not complete within %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_cmd(input logic [2:0] op, input logic [7:0] stype,
                          input logic [7:0] sid, input logic [1:0] ack);
    cmd_t c;
    c.op = op;
    c.stype = stype;
    c.sid = sid;
    c.ack = ack;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      sirl_pkg::CFG_TICK_DIVIDER: div_cfg = val;
      sirl_pkg::CFG_LIMIT:        limit_cfg = val;
      sirl_pkg::CFG_EXEMPT_TYPE:  exempt_type_cfg = val;
      sirl_pkg::CFG_EXEMPT_ID:    exempt_id_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] dv, input logic [7:0] lim,
                            input logic [7:0] et, input logic [7:0] eid);
    wait_drained();
    write_reg(sirl_pkg::CFG_TICK_DIVIDER, dv);
    write_reg(sirl_pkg::CFG_LIMIT, lim);
    write_reg(sirl_pkg::CFG_EXEMPT_TYPE, et);
    write_reg(sirl_pkg::CFG_EXEMPT_ID, eid);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] pool [4] = '{8'h01, 8'h02, 8'h80, 8'hFF};
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return pool[$urandom_range(3)];
  endfunction

  function automatic logic [7:0] pick_id();
    logic [7:0] pool [4] = '{8'h00, 8'h01, 8'h7F, 8'hFF};
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return pool[$urandom_range(3)];
  endfunction

  function automatic cmd_t gen_cmd(input bit sat_mix);
    cmd_t c;
    int r;
    int k;
    r = $urandom_range(99);
    c.stype = 8'($urandom_range(255));
    c.sid = 8'($urandom_range(255));
    c.ack = 2'($urandom_range(3));
    if (sat_mix) begin
      // drive credit and one source's counter into saturation
      if (r < 45) begin
        c.op = sirl_pkg::OP_ACK;
        c.ack = sirl_pkg::ACK_DONE;
      end else if (r < 97) begin
        c.op = sirl_pkg::OP_RAISE;
        c.stype = exempt_type_cfg;
        c.sid = exempt_id_cfg;
      end else begin
        c.op = sirl_pkg::OP_TICK;
      end
    end else begin
      if (r < 22) c.op = sirl_pkg::OP_REGISTER;
      else if (r < 58) c.op = sirl_pkg::OP_RAISE;
      else if (r < 72) c.op = sirl_pkg::OP_TICK;
      else if (r < 88) c.op = sirl_pkg::OP_ACK;
      else if (r < 91) c.op = sirl_pkg::OP_CLEAR;
      else if (r < 94) c.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      else c.op = r[0] ? sirl_pkg::OP_REGISTER : sirl_pkg::OP_RAISE;
      if ((c.op == sirl_pkg::OP_REGISTER || c.op == sirl_pkg::OP_RAISE) && r < 94) begin
        c.stype = pick_type();
        c.sid = pick_id();
      end
      if (c.op == sirl_pkg::OP_ACK) begin
        k = $urandom_range(99);
        if (k < 12) c.ack = sirl_pkg::ACK_BUSY;
        else if (k < 75) c.ack = sirl_pkg::ACK_DONE;
        else c.ack = $urandom_range(1) ? ACK_PROGRESS : ACK_NONE;
      end
    end
    return c;
  endfunction

  task automatic run_random(input logic [7:0] dv, input logic [7:0] lim,
                            input logic [7:0] et, input logic [7:0] eid,
                            input int idle_s, input int idle_r, input int hold,
                            input int n_items, input bit sat_mix);
    set_config(dv, lim, et, eid);
    sender_idle = idle_s;
    recv_stall = idle_r;
    hold_left = hold;
    if (sat_mix) begin
      push_cmd(sirl_pkg::OP_CLEAR, 8'h00, 8'h00, ACK_NONE);
      push_cmd(sirl_pkg::OP_REGISTER, et, eid, ACK_NONE);
    end
    for (int n = 0; n < n_items; n++) pending_cmds.push_back(gen_cmd(sat_mix));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: unregistered, type zero, duplicate, limit, credit
    push_cmd(sirl_pkg::OP_RAISE, 8'h01, 8'h01, sirl_pkg::ACK_DONE);
    push_cmd(sirl_pkg::OP_REGISTER, 8'h00, 8'h05, ACK_NONE);
    push_cmd(sirl_pkg::OP_RAISE, 8'h00, 8'h00, ACK_NONE);
    push_cmd(sirl_pkg::OP_REGISTER, 8'h01, 8'h01, ACK_NONE);
    push_cmd(sirl_pkg::OP_REGISTER, 8'h01, 8'h01, sirl_pkg::ACK_BUSY);
    push_cmd(sirl_pkg::OP_REGISTER, 8'hFF, 8'hFF, ACK_NONE);
    repeat (4) push_cmd(sirl_pkg::OP_RAISE, 8'h01, 8'h01, ACK_NONE);
    push_cmd(sirl_pkg::OP_ACK, 8'h00, 8'h00, sirl_pkg::ACK_BUSY);
    push_cmd(sirl_pkg::OP_RAISE, 8'hFF, 8'hFF, ACK_NONE);
    push_cmd(sirl_pkg::OP_ACK, 8'hFF, 8'hFF, sirl_pkg::ACK_DONE);
    push_cmd(sirl_pkg::OP_TICK, 8'h00, 8'h00, ACK_PROGRESS);

    // divider zero, limit zero, exempt pair, full table, spare codes, clear
    set_config(8'd0, 8'd0, 8'hFF, 8'hFF);
    push_cmd(sirl_pkg::OP_TICK, 8'h00, 8'h00, ACK_NONE);
    push_cmd(sirl_pkg::OP_RAISE, 8'hFF, 8'hFF, ACK_NONE);
    push_cmd(sirl_pkg::OP_RAISE, 8'h01, 8'h01, ACK_NONE);
    for (int k = 0; k < TBL_DEPTH - 2; k++)
      push_cmd(sirl_pkg::OP_REGISTER, 8'h80, 8'(k), ACK_NONE);
    push_cmd(sirl_pkg::OP_REGISTER, 8'h7F, 8'h80, ACK_NONE);
    push_cmd(OP_SPARE_LO, 8'h01, 8'h01, sirl_pkg::ACK_BUSY);
    push_cmd(OP_SPARE_HI, 8'hFF, 8'hFF, sirl_pkg::ACK_BUSY);
    push_cmd(sirl_pkg::OP_CLEAR, 8'h00, 8'h00, ACK_NONE);
    push_cmd(sirl_pkg::OP_RAISE, 8'hFF, 8'hFF, ACK_NONE);

    // long sink hold-off in the first phase backs the block up
    run_random(8'd4,   8'd2,   8'h01, 8'h00, 0,  0,  300, 120, 1'b0);
    run_random(8'd255, 8'd255, 8'h00, 8'hFF, 88, 0,  0,   120, 1'b0);
    run_random(8'd1,   8'd1,   8'h80, 8'h01, 0,  88, 0,   120, 1'b0);
    run_random(8'd7,   8'd0,   8'hFF, 8'h00, 24, 24, 0,   120, 1'b0);
    run_random(8'd255, 8'd3,   8'h02, 8'hFF, 24, 24, 0,   640, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
